// ===== src/column_predicate_bitmap_filter_assert.svh =====
// Assertion macros for the column predicate bitmap filter.
// CPBF_ASSERT:     checked while out of reset.
// CPBF_ASSERT_ANY: checked at every edge, reset included.
`ifndef COLUMN_PREDICATE_BITMAP_FILTER_ASSERT_SVH
`define COLUMN_PREDICATE_BITMAP_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define CPBF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cpbf assertion failed");

`define CPBF_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cpbf assertion failed");

`else

`define CPBF_ASSERT(lbl, clk, rstn, prop)

`define CPBF_ASSERT_ANY(lbl, clk, prop)

`endif

`endif

// ===== src/cpbf_pkg.sv =====
package cpbf_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CountW  = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCompareMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegColumnWide  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBoundLo     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegBoundHi     = CfgIdxW'(3);

  typedef enum logic [2:0] {
    CmpLess         = 3'd0,
    CmpLessEqual    = 3'd1,
    CmpGreater      = 3'd2,
    CmpGreaterEqual = 3'd3,
    CmpEqual        = 3'd4,
    CmpBetween      = 3'd5
  } cmp_mode_e;

  typedef struct packed {
    cmp_mode_e         mode;
    logic              wide;
    logic [DataW-1:0]  lo;
    logic [DataW-1:0]  hi;
  } cpbf_cfg_t;

endpackage

// ===== src/cpbf_if.sv =====
// Row input stream.
interface cpbf_row_if import cpbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] column_value;
  logic             last_row;

  modport source (output valid, output column_value, output last_row, input ready);
  modport sink   (input valid, input column_value, input last_row, output ready);
endinterface

// Packed bitmap output stream.
interface cpbf_bitmap_if import cpbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  packed_bits;
  logic [CountW-1:0] bit_count;
  logic              block_end;

  modport source (output valid, output packed_bits, output bit_count, output block_end,
                  input ready);
  modport sink   (input valid, input packed_bits, input bit_count, input block_end,
                  output ready);
endinterface

// Configuration write channel.
interface cpbf_cfg_if import cpbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cpbf_compare.sv =====
module cpbf_compare import cpbf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  cpbf_cfg_t        cfg_i,
  input  logic [DataW-1:0] value_i,
  output logic             match_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [VW-1:0] SignBit = VW'(1) << (VW - 1);

  logic [VW-1:0] key_x, key_lo;
  logic [VW-1:0] off_w, span_w, off, span;

  // Signed order maps onto unsigned order by flipping the sign bit.
  assign key_x  = cfg_i.wide ? (value_i[VW-1:0] ^ SignBit) : VW'(value_i[7:0]);
  assign key_lo = cfg_i.wide ? (cfg_i.lo[VW-1:0] ^ SignBit) : VW'(cfg_i.lo[7:0]);

  // Between: unsigned (x - lo) <= (hi - lo), modulo the column width.
  assign off_w  = value_i[VW-1:0] - cfg_i.lo[VW-1:0];
  assign span_w = cfg_i.hi[VW-1:0] - cfg_i.lo[VW-1:0];
  assign off    = cfg_i.wide ? off_w  : VW'(off_w[7:0]);
  assign span   = cfg_i.wide ? span_w : VW'(span_w[7:0]);

  always_comb begin
    case (cfg_i.mode)
      CmpLess:         match_o = key_x <  key_lo;
      CmpLessEqual:    match_o = key_x <= key_lo;
      CmpGreater:      match_o = key_x >  key_lo;
      CmpGreaterEqual: match_o = key_x >= key_lo;
      CmpEqual:        match_o = key_x == key_lo;
      CmpBetween:      match_o = off <= span;
      default:         match_o = 1'b0;
    endcase
  end

endmodule

// ===== src/column_predicate_bitmap_filter.sv =====
// Column predicate bitmap filter.
// row_i (sink): one column value per transfer plus a last_row flag.
// bitmap_o (source): one byte of match bits per transfer, row k of the group
//   at bit k, bit_count valid bits (1..8), block_end set on the byte that
//   closes a block. Unused upper bits are zero.
// cfg_i (sink): register writes, always ready. Index 0 compare mode, 1 column
//   width select, 2 lower bound, 3 upper bound; other indexes are dropped.
//   Write only while the filter is idle.
// Throughput: one row per cycle unless a closing row stalls (see Stall). A row
//   accepted lands in the input register; its byte, if it closes one, goes from there to the output register.
// Rate is set by the input register -> compare/insert -> output register path;
//   each row is one compare and one bit insert.
// Stall: the output register holds while bitmap_o.ready is low; rows that do
//   not close a byte keep flowing, and row_i.ready drops only when a closing
//   row finds the output register still full.
// Reset (rst_ni low, async): stream empty, accumulator and position cleared,
//   mode less, wide signed column, both bounds zero.
// VALUE_WIDTH (8..64) sets the signed column width; ports stay 64 bits.
`include "column_predicate_bitmap_filter_assert.svh"

module column_predicate_bitmap_filter import cpbf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpbf_row_if.sink     row_i,
  cpbf_cfg_if.sink     cfg_i,
  cpbf_bitmap_if.source bitmap_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cpbf_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= CmpLess;
      cfg_q.wide <= 1'b1;
      cfg_q.lo   <= '0;
      cfg_q.hi   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        RegCompareMode: cfg_q.mode <= cmp_mode_e'(cfg_i.data[2:0]);
        RegColumnWide:  cfg_q.wide <= cfg_i.data[0];
        RegBoundLo:     cfg_q.lo   <= cfg_i.data;
        RegBoundHi:     cfg_q.hi   <= cfg_i.data;
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic             s1_valid_q, s1_valid_d;
  logic [DataW-1:0] s1_value_q;
  logic             s1_last_q;
  logic             s1_fire;

  // Input register is free when empty or moving on this cycle.
  assign row_i.ready = !s1_valid_q || s1_fire;

  assign s1_valid_d = row_i.ready ? row_i.valid : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_i.valid && row_i.ready) begin
      s1_value_q <= row_i.column_value;
      s1_last_q  <= row_i.last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare and bit insert
  // ---------------------------------------------------------------------------
  logic              match;
  logic [ByteW-1:0]  acc_q, acc_d, acc_set;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] count;
  logic              emit;

  cpbf_compare #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_compare (
    .cfg_i   (cfg_q),
    .value_i (s1_value_q),
    .match_o (match)
  );

  assign acc_set = acc_q | (ByteW'(match) << pos_q);
  assign count   = CountW'(pos_q) + CountW'(1);
  assign emit    = (pos_q == '1) || s1_last_q;

  // Rows that do not close a byte never wait on the output side.
  logic out_valid_q, out_valid_d;
  assign s1_fire = s1_valid_q && (!emit || !out_valid_q || bitmap_o.ready);

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (s1_fire) begin
      if (emit) begin
        acc_d = '0;
        pos_d = '0;
      end else begin
        acc_d = acc_set;
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0]  out_bits_q;
  logic [CountW-1:0] out_count_q;
  logic              out_end_q;

  always_comb begin
    if (s1_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (bitmap_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_bits_q  <= acc_set;
      out_count_q <= count;
      out_end_q   <= s1_last_q;
    end
  end

  assign bitmap_o.valid       = out_valid_q;
  assign bitmap_o.packed_bits = out_bits_q;
  assign bitmap_o.bit_count   = out_count_q;
  assign bitmap_o.block_end   = out_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CPBF_ASSERT(a_acc_above_pos_clear, clk_i, rst_ni, (acc_q >> pos_q) == '0)
  `CPBF_ASSERT(a_emit_clears, clk_i, rst_ni, (s1_fire && emit) |=> (acc_q == '0 && pos_q == '0))
  `CPBF_ASSERT(a_stall_only_on_full_out, clk_i, rst_ni,
               (s1_valid_q && !s1_fire) |-> (out_valid_q && !bitmap_o.ready))
  `CPBF_ASSERT(a_partial_only_at_end, clk_i, rst_ni,
               (out_valid_q && !out_end_q) |-> (out_count_q == CountW'(ByteW)))
  `CPBF_ASSERT(a_padding_zero, clk_i, rst_ni,
               out_valid_q |-> (out_count_q != '0 && (out_bits_q >> out_count_q) == '0))

endmodule

// ===== bench/column_predicate_bitmap_filter_test.sv =====
`timescale 1ns / 100ps

// Bench for the column predicate bitmap filter.
// Rows go in on row_if and packed match bytes come out on bm_if. A local model of
// the compare and the bit packer predicts each byte, and bytes are checked in order.
// Config writes on cfg_if happen only while the filter is drained.
module column_predicate_bitmap_filter_test;
  import cpbf_pkg::*;

  // Compare codes that the package enum leaves out. They never match.
  localparam logic [2:0] CmpSpare6 = 3'd6;
  localparam logic [2:0] CmpSpare7 = 3'd7;

  // Register indexes past the end of the map. Writes to them are dropped.
  localparam logic [CfgIdxW-1:0] RegUnusedLow  = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegUnusedHigh = CfgIdxW'(255);

  localparam logic [63:0] ColMin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ColMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AllOne = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int RandPhases = 8;
  localparam int RowsPerPhase = 118;
  localparam int HoldCycles = 300;  // long receiver hold-off, backs the filter up
  localparam int DrainCycles = 4;   // a closing row's byte passes the input and output registers; add margin

  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] count;
    logic       block_end;
  } bitmap_byte_t;

  localparam bitmap_byte_t NoByte = '0;

  // One line of the directed plan. It is either a register write or a row.
  // When typed is set, want replaces the model's prediction for that row.
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [63:0]        data;
    logic               last;
    logic               typed;
    bitmap_byte_t       want;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpbf_row_if    row_if ();
  cpbf_cfg_if    cfg_if ();
  cpbf_bitmap_if bm_if ();

  column_predicate_bitmap_filter #(
    .VALUE_WIDTH(64)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .row_i   (row_if),
    .cfg_i   (cfg_if),
    .bitmap_o(bm_if)
  );

  always #5 clk = ~clk;

  // Local copy of the filter registers and the byte being packed.
  logic [2:0]  filt_mode = CmpLess;
  logic        filt_wide = 1'b1;
  logic [63:0] filt_lo = '0;
  logic [63:0] filt_hi = '0;
  logic [7:0]  pend_bits = '0;
  logic [2:0]  pend_pos = '0;

  bitmap_byte_t bytes_due[$];  // predicted bytes, oldest first

  // Traffic shaping. Only the main sequence writes these.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  bit typed_on = 1'b0;
  bitmap_byte_t typed_byte = NoByte;

  int errors = 0;
  int rows_seen = 0;
  int bytes_seen = 0;
  int cfg_seen = 0;

  // Directed plan. The first rows run on the reset settings: less than zero, wide column.
  plan_step_t directed_plan [46] = '{
    // A negative value is below zero. The last-row flag flushes one bit.
    '{1'b0, '0, AllOne, 1'b1, 1'b1, '{8'h01, 4'd1, 1'b1}},
    // Extremes alternate. The full byte closes without block_end.
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b1, '{8'h55, 4'd8, 1'b0}},
    // Top and bottom of the signed range, each against itself.
    '{1'b1, RegBoundLo,     ColMax,               1'b0, 1'b0, NoByte},
    '{1'b1, RegCompareMode, 64'(CmpLessEqual),    1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b1, 1'b1, '{8'h01, 4'd1, 1'b1}},
    '{1'b1, RegCompareMode, 64'(CmpGreater),      1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b1, 1'b1, '{8'h00, 4'd1, 1'b1}},
    '{1'b1, RegBoundLo,     ColMin,               1'b0, 1'b0, NoByte},
    '{1'b1, RegCompareMode, 64'(CmpGreaterEqual), 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b1, 1'b1, '{8'h01, 4'd1, 1'b1}},
    // Narrow column, between range that wraps past 255. Bound upper bits are junk.
    '{1'b1, RegColumnWide,  64'h0,                1'b0, 1'b0, NoByte},
    '{1'b1, RegCompareMode, 64'(CmpBetween),      1'b0, 1'b0, NoByte},
    '{1'b1, RegBoundLo,     64'hABCD_EF01_2345_67F0, 1'b0, 1'b0, NoByte},
    '{1'b1, RegBoundHi,     64'h5432_10FE_DCBA_980F, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0000_0000_0000_00F8, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'hFFFF_FFFF_FFFF_FF05, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0123_4567_89AB_CD80, 1'b1, 1'b0, NoByte},
    // Narrow equal ignores everything above bit 7.
    '{1'b1, RegCompareMode, 64'(CmpEqual),        1'b0, 1'b0, NoByte},
    '{1'b1, RegBoundLo,     64'h1234_5678_9ABC_DE55, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'hFFFF_FFFF_FFFF_AA55, 1'b1, 1'b0, NoByte},
    // Writes past the register map must leave the settings as they were.
    '{1'b1, RegUnusedLow,   64'h0,                1'b0, 1'b0, NoByte},
    '{1'b1, RegUnusedHigh,  AllOne,               1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0000_0000_0000_0055, 1'b1, 1'b0, NoByte},
    // Spare compare codes never match. Only the low 3 bits of the data count.
    '{1'b1, RegCompareMode, {61'h1FFF_FFFF_FFFF_FFFF, CmpSpare6}, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0000_0000_0000_0055, 1'b1, 1'b1, '{8'h00, 4'd1, 1'b1}},
    '{1'b1, RegCompareMode, {61'h0, CmpSpare7},   1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0, 1'b1, 1'b1, '{8'h00, 4'd1, 1'b1}},
    // Wide between with hi below lo. The span wraps to 1, so max and min both pass.
    // The last row also fills the byte.
    '{1'b1, RegColumnWide,  AllOne,               1'b0, 1'b0, NoByte},
    '{1'b1, RegCompareMode, 64'(CmpBetween),      1'b0, 1'b0, NoByte},
    '{1'b1, RegBoundLo,     ColMax,               1'b0, 1'b0, NoByte},
    '{1'b1, RegBoundHi,     ColMin,               1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h0,  1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMin, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, 64'h1,  1'b0, 1'b0, NoByte},
    '{1'b0, '0, AllOne, 1'b0, 1'b0, NoByte},
    '{1'b0, '0, ColMax, 1'b1, 1'b0, NoByte}
  };

  // Compare one column value against the current settings.
  // Narrow: low byte, unsigned. Wide: full 64 bits, signed. Between is
  // (x - lo) <= (hi - lo) unsigned, taken at the column width.
  function automatic logic row_hit(input logic [63:0] x);
    logic [63:0] off;
    logic [63:0] span;
    logic        lt;
    logic        eq;
    off  = x - filt_lo;
    span = filt_hi - filt_lo;
    if (filt_wide) begin
      lt = $signed(x) < $signed(filt_lo);
      eq = x == filt_lo;
    end else begin
      lt = x[7:0] < filt_lo[7:0];
      eq = x[7:0] == filt_lo[7:0];
      off[63:8]  = '0;
      span[63:8] = '0;
    end
    case (filt_mode)
      CmpLess:         return lt;
      CmpLessEqual:    return lt | eq;
      CmpGreater:      return !(lt | eq);
      CmpGreaterEqual: return !lt;
      CmpEqual:        return eq;
      CmpBetween:      return off <= span;
      default:         return 1'b0;
    endcase
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Scoreboard. Every signal is read at the rising edge, so it sees the
  // values from before the edge.
  always @(posedge clk) begin : scoreboard
    bitmap_byte_t due;
    bitmap_byte_t seen;
    logic         closes;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_seen++;
        case (cfg_if.index)
          RegCompareMode: filt_mode = cfg_if.data[2:0];
          RegColumnWide:  filt_wide = cfg_if.data[0];
          RegBoundLo:     filt_lo = cfg_if.data;
          RegBoundHi:     filt_hi = cfg_if.data;
          default: ;
        endcase
      end
      if (row_if.valid && row_if.ready) begin
        rows_seen++;
        if (row_hit(row_if.column_value)) pend_bits[pend_pos] = 1'b1;
        closes = (pend_pos == 3'd7) || row_if.last_row;
        due = NoByte;
        if (closes) begin
          due.bits = pend_bits;
          due.count = {1'b0, pend_pos} + 4'd1;
          due.block_end = row_if.last_row;
          pend_bits = '0;
          pend_pos = '0;
        end else begin
          pend_pos++;
        end
        // A typed row expects the byte written in the plan.
        if (typed_on) bytes_due.push_back(typed_byte);
        else if (closes) bytes_due.push_back(due);
      end
      if (bm_if.valid && bm_if.ready) begin
        bytes_seen++;
        seen = '{bm_if.packed_bits, bm_if.bit_count, bm_if.block_end};
        if (bytes_due.size() == 0) begin
          flag($sformatf("byte with nothing pending: bits %02h count %0d end %0b",
                         seen.bits, seen.count, seen.block_end));
        end else begin
          due = bytes_due.pop_front();
          if (seen.bits != due.bits || seen.count != due.count ||
              seen.block_end != due.block_end)
            flag($sformatf("byte mismatch: want bits %02h count %0d end %0b, got %02h %0d %0b",
                           due.bits, due.count, due.block_end,
                           seen.bits, seen.count, seen.block_end));
        end
      end
    end
  end

  // Receiver. It stalls at random. A long hold starts each time the main
  // sequence bumps hold_token, and this process counts the hold down itself.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      bm_if.ready = 1'b0;
    end else begin
      bm_if.ready = $urandom_range(99) >= stall_pct;
    end
  end

  // Stop sending rows, wait for every pending byte, then give the pipeline time
  // to finish a row that closes nothing. After this the filter is idle.
  task automatic settle();
    row_if.valid = 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    settle();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Offer one row, maybe after some idle cycles, and hold it until it is accepted.
  // valid stays high on return, so a row that follows at once goes out back to back.
  task automatic send_row(input logic [63:0] v, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      row_if.valid = 1'b0;
      @(negedge clk);
    end
    row_if.valid = 1'b1;
    row_if.column_value = v;
    row_if.last_row = l;
    @(posedge clk);
    while (!row_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Bounds: extremes, values near zero, and fully random ones.
  function automatic logic [63:0] pick_bound();
    case ($urandom_range(5))
      0:       return ColMin;
      1:       return ColMax;
      2:       return '0;
      3:       return AllOne;
      4:       return 64'(int'($urandom_range(600)) - 300);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : main_seq
    int          idle_set [4];
    int          stall_set [4];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] v;
    logic [2:0]  mode;
    logic        wide;
    logic        last;
    idle_set = '{0, 79, 0, 13};
    stall_set = '{0, 0, 79, 13};
    row_if.valid = 1'b0;
    row_if.column_value = '0;
    row_if.last_row = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    bm_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed plan, run with no idling on either side.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        typed_on = 1'b0;
        cfg_write(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        typed_on = directed_plan[i].typed;
        typed_byte = directed_plan[i].want;
        send_row(directed_plan[i].data, directed_plan[i].last);
      end
    end
    typed_on = 1'b0;

    // Random phases. Each phase writes all four registers, then streams rows
    // near the bounds, at the extremes and at random, with random block lengths.
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        // Wide between over the whole signed range. Every row matches.
        wide = 1'b1; mode = CmpBetween; lo = ColMin; hi = ColMax;
      end else if (p == 1) begin
        // Narrow less-equal against 255. Every row matches.
        wide = 1'b0; mode = CmpLessEqual; lo = AllOne; hi = '0;
      end else begin
        wide = 1'($urandom_range(1));
        mode = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        lo = pick_bound();
        hi = pick_bound();
      end
      cfg_write(RegColumnWide, {$urandom, 31'($urandom_range(32'h7FFF_FFFF)), wide});
      cfg_write(RegCompareMode, {$urandom, 29'($urandom_range(32'h1FFF_FFFF)), mode});
      cfg_write(RegBoundLo, lo);
      cfg_write(RegBoundHi, hi);
      if ($urandom_range(2) == 0)
        cfg_write(CfgIdxW'($urandom_range(255, 4)), {$urandom, $urandom});

      idle_pct = idle_set[p % 4];
      stall_pct = stall_set[p % 4];
      // Hold the receiver for a long time while rows keep coming.
      if (p == 4) hold_token++;

      for (int n = 0; n < RowsPerPhase; n++) begin
        // Halfway through one phase the sender waits until every byte is in.
        if (p == 2 && n == RowsPerPhase / 2) settle();
        case ($urandom_range(9))
          0:       v = lo;
          1:       v = lo + 1;
          2:       v = lo - 1;
          3:       v = hi;
          4:       v = hi + 1;
          5:       v = hi - 1;
          6:       v = ColMin;
          7:       v = ColMax;
          default: v = {$urandom, $urandom};
        endcase
        if (!wide && $urandom_range(1)) v[63:8] = 56'({$urandom, $urandom});
        // Close the phase on a last row so that no byte is half full.
        last = (n == RowsPerPhase - 1) || ($urandom_range(11) == 0);
        send_row(v, last);
      end
      row_if.valid = 1'b0;
    end
    row_if.valid = 1'b0;

    // Final drain with a bound. Anything still pending after that is a failure.
    for (int c = 0; c < 5000 && bytes_due.size() != 0; c++) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (bytes_due.size() != 0)
      flag($sformatf("%0d predicted bytes never arrived", bytes_due.size()));

    $display("rows %0d, bytes %0d, register writes %0d, mismatches %0d",
             rows_seen, bytes_seen, cfg_seen, errors);
    $display("all compare codes on narrow and wide columns, idle and stall on both sides");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/cpbf_pkg.sv
src/cpbf_if.sv
src/cpbf_compare.sv
src/column_predicate_bitmap_filter.sv
bench/column_predicate_bitmap_filter_test.sv
